// ===== rtl/cdp_pkg.sv =====
// Shared types and constants for the cookie date parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cdp_pkg;

  typedef struct packed {
    logic        hour_ok;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic        year_set;
    logic        year_big;
    logic [14:0] year;
  } date_fields_t;

  typedef enum logic [2:0] {
    EV_IDLE,
    EV_CHECK,
    EV_DIV,
    EV_DAYS,
    EV_MUL,
    EV_SUM,
    EV_OUT
  } ev_state_t;

  localparam int unsigned YEAR_MIN = 1601;
  localparam int unsigned YEAR_MAX = 32767;

  function automatic logic is_delim(input logic [7:0] b);
    return (b == 8'h09) || (b >= 8'h20 && b <= 8'h2F) || (b >= 8'h3B && b <= 8'h40) ||
           (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) ? (b | 8'h20) : b;
  endfunction

  function automatic logic [3:0] month_code(input logic [23:0] p);
    logic [23:0] k;
    k = {fold_case(p[7:0]), fold_case(p[15:8]), fold_case(p[23:16])};
    unique case (k)
      "jan": return 4'd1;
      "feb": return 4'd2;
      "mar": return 4'd3;
      "apr": return 4'd4;
      "may": return 4'd5;
      "jun": return 4'd6;
      "jul": return 4'd7;
      "aug": return 4'd8;
      "sep": return 4'd9;
      "oct": return 4'd10;
      "nov": return 4'd11;
      "dec": return 4'd12;
      default: return 4'd0;
    endcase
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
    unique case (m)
      4'd2: return lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cdp_front.sv =====
// Byte tokenizer and field rules; emits collected date fields on the last byte.
// Depends on cdp_pkg and cdp_final.
`timescale 1ns / 1ps
`default_nettype none
module cdp_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [7:0]            date_byte,
  input  wire logic                  last_byte,
  input  wire logic                  valid,
  output logic                       ready,
  output cdp_pkg::date_fields_t      fields,
  output logic                       fields_valid,
  input  wire logic                  fields_ready
);
  import cdp_pkg::*;

  logic [7:0]  tlen;
  logic [23:0] prefix;
  logic        nondig, noncolon;
  logic [1:0]  colons;
  logic [6:0]  grp [3];
  logic [2:0]  grp_has;
  logic [62:0] num;
  logic        ovf;
  date_fields_t acc, acc_next;
  logic        take;

  logic        dig;
  logic [3:0]  d;
  logic [6:0]  gv;
  logic [66:0] prod;

  assign ready = !fields_valid || fields_ready;
  assign take  = valid && ready;
  assign dig   = date_byte >= 8'h30 && date_byte <= 8'h39;
  assign d     = date_byte[3:0];

  always_comb begin
    logic [3:0] m;
    acc_next = acc;
    m = month_code(prefix);
    if (tlen != 8'd0) begin
      if (!acc.hour_ok && colons == 2'd2 && !noncolon && (&grp_has) &&
          grp[0] <= 7'd23 && grp[1] <= 7'd59 && grp[2] <= 7'd59) begin
        acc_next.hour_ok = 1'b1;
        acc_next.hour    = grp[0][4:0];
        acc_next.minute  = grp[1][5:0];
        acc_next.second  = grp[2][5:0];
      end else if (acc.day == 5'd0 && !nondig && tlen <= 8'd2 && num >= 63'd1 &&
                   num <= 63'd31) begin
        acc_next.day = num[4:0];
      end else if (acc.month == 4'd0 && tlen >= 8'd3 && m != 4'd0) begin
        acc_next.month = m;
      end else if (!acc.year_set && !nondig && !ovf) begin
        acc_next.year_set = 1'b1;
        acc_next.year_big = num > 63'd32767;
        acc_next.year     = num > 63'd32767 ? 15'd0 : num[14:0];
      end
    end
  end

  assign gv   = grp[colons == 2'd3 ? 2'd2 : colons];
  assign prod = {4'd0, num} * 67'd10 + {63'd0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      tlen <= '0; prefix <= '0; nondig <= 1'b0; noncolon <= 1'b0; colons <= '0;
      grp[0] <= '0; grp[1] <= '0; grp[2] <= '0; grp_has <= '0; num <= '0; ovf <= 1'b0;
      acc <= '0;
      fields_valid <= 1'b0;
    end else begin
      if (fields_valid && fields_ready) fields_valid <= 1'b0;
      if (take) begin
        if (is_delim(date_byte)) begin
          acc <= acc_next;
          tlen <= '0; prefix <= '0; nondig <= 1'b0; noncolon <= 1'b0; colons <= '0;
          grp[0] <= '0; grp[1] <= '0; grp[2] <= '0; grp_has <= '0; num <= '0;
          ovf <= 1'b0;
        end else begin
          if (tlen < 8'd3) prefix[tlen[1:0]*8 +: 8] <= date_byte;
          if (tlen != 8'd255) tlen <= tlen + 8'd1;
          if (dig) begin
            if (colons != 2'd3) begin
              grp[colons] <= ({gv, 3'd0} + {2'd0, gv, 1'b0} + {6'd0, d}) > 10'd100 ?
                             7'd100 : 7'(({gv, 3'd0} + {2'd0, gv, 1'b0} + {6'd0, d}));
              grp_has[colons] <= 1'b1;
            end
            if (!ovf) begin
              if (prod[66:63] != 4'd0) ovf <= 1'b1;
              else num <= prod[62:0];
            end
          end else begin
            nondig <= 1'b1;
            if (date_byte == 8'h3A) begin
              if (colons != 2'd3) colons <= colons + 2'd1;
            end else begin
              noncolon <= 1'b1;
            end
          end
        end
        if (last_byte) begin
          fields_valid <= 1'b1;
          acc <= '0;
          tlen <= '0; prefix <= '0; nondig <= 1'b0; noncolon <= 1'b0; colons <= '0;
          grp[0] <= '0; grp[1] <= '0; grp[2] <= '0; grp_has <= '0; num <= '0;
          ovf <= 1'b0;
        end
      end
    end
  end

  // last byte: compute the fields with that byte folded in and one more finish
  date_fields_t last_f;
  cdp_final u_final (
    .date_byte (date_byte),
    .tlen      (tlen),
    .prefix    (prefix),
    .nondig    (nondig),
    .noncolon  (noncolon),
    .colons    (colons),
    .grp0      (grp[0]),
    .grp1      (grp[1]),
    .grp2      (grp[2]),
    .grp_has   (grp_has),
    .num       (num),
    .ovf       (ovf),
    .acc       (acc),
    .acc_tok   (acc_next),
    .result    (last_f)
  );

  always_ff @(posedge clk) begin
    if (take && last_byte) fields <= last_f;
  end

endmodule
`default_nettype wire

// ===== rtl/cdp_final.sv =====
// Folds the last byte into the token and applies the field rules once more.
// Depends on cdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cdp_final (
  input  wire logic [7:0]            date_byte,
  input  wire logic [7:0]            tlen,
  input  wire logic [23:0]           prefix,
  input  wire logic                  nondig,
  input  wire logic                  noncolon,
  input  wire logic [1:0]            colons,
  input  wire logic [6:0]            grp0,
  input  wire logic [6:0]            grp1,
  input  wire logic [6:0]            grp2,
  input  wire logic [2:0]            grp_has,
  input  wire logic [62:0]           num,
  input  wire logic                  ovf,
  input  wire cdp_pkg::date_fields_t acc,
  input  wire cdp_pkg::date_fields_t acc_tok,
  output cdp_pkg::date_fields_t      result
);
  import cdp_pkg::*;

  always_comb begin
    logic [7:0]  t;
    logic [23:0] p;
    logic        nd, nc, dig, o;
    logic [1:0]  c;
    logic [6:0]  g [3];
    logic [2:0]  gh;
    logic [62:0] n;
    logic [66:0] pr;
    logic [9:0]  gvn;
    logic [3:0]  m;
    date_fields_t a;
    t = tlen; p = prefix; nd = nondig; nc = noncolon; c = colons;
    g[0] = grp0; g[1] = grp1; g[2] = grp2; gh = grp_has; n = num; o = ovf;
    dig = date_byte >= 8'h30 && date_byte <= 8'h39;
    pr = {4'd0, num} * 67'd10 + {63'd0, date_byte[3:0]};
    gvn = '0;
    if (is_delim(date_byte)) begin
      a = acc_tok;
      t = '0; p = '0; nd = 1'b0; nc = 1'b0; c = '0; g[0] = '0; g[1] = '0; g[2] = '0;
      gh = '0; n = '0; o = 1'b0;
    end else begin
      a = acc;
      if (tlen < 8'd3) p[tlen[1:0]*8 +: 8] = date_byte;
      if (tlen != 8'd255) t = tlen + 8'd1;
      if (dig) begin
        if (colons != 2'd3) begin
          gvn = {g[colons], 3'd0} + {2'd0, g[colons], 1'b0} + {6'd0, date_byte[3:0]};
          g[colons] = gvn > 10'd100 ? 7'd100 : gvn[6:0];
          gh[colons] = 1'b1;
        end
        if (!ovf) begin
          if (pr[66:63] != 4'd0) o = 1'b1;
          else n = pr[62:0];
        end
      end else begin
        nd = 1'b1;
        if (date_byte == 8'h3A) begin
          if (colons != 2'd3) c = colons + 2'd1;
        end else begin
          nc = 1'b1;
        end
      end
    end
    m = month_code(p);
    result = a;
    if (t != 8'd0) begin
      if (!a.hour_ok && c == 2'd2 && !nc && (&gh) &&
          g[0] <= 7'd23 && g[1] <= 7'd59 && g[2] <= 7'd59) begin
        result.hour_ok = 1'b1;
        result.hour    = g[0][4:0];
        result.minute  = g[1][5:0];
        result.second  = g[2][5:0];
      end else if (a.day == 5'd0 && !nd && t <= 8'd2 && n >= 63'd1 && n <= 63'd31) begin
        result.day = n[4:0];
      end else if (a.month == 4'd0 && t >= 8'd3 && m != 4'd0) begin
        result.month = m;
      end else if (!a.year_set && !nd && !o) begin
        result.year_set = 1'b1;
        result.year_big = n > 63'd32767;
        result.year     = n > 63'd32767 ? 15'd0 : n[14:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cdp_queue.sv =====
// Two-entry queue of date field sets between tokenizer and converter.
// Depends on cdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cdp_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cdp_pkg::date_fields_t in_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output cdp_pkg::date_fields_t      out_data,
  output logic                       out_valid,
  input  wire logic                  out_ready
);
  import cdp_pkg::*;

  date_fields_t mem [2];
  logic         wptr, rptr;
  logic [1:0]   count;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0; rptr <= 1'b0; count <= '0;
    end else begin
      if (in_valid && in_ready) begin
        mem[wptr] <= in_data;
        wptr <= ~wptr;
      end
      if (out_valid && out_ready) rptr <= ~rptr;
      count <= count + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !(in_valid && in_ready)) else $error("queue overflow");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue count out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("queue lost entry");

endmodule
`default_nettype wire

// ===== rtl/cdp_back.sv =====
// Validates date fields and converts them to seconds since 1970 over several cycles.
// Depends on cdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cdp_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cdp_pkg::date_fields_t fields,
  input  wire logic                  fields_valid,
  output logic                       fields_ready,
  output logic                       date_valid,
  output logic signed [40:0]         epoch_seconds,
  output logic                       valid,
  input  wire logic                  ready
);
  import cdp_pkg::*;

  // quotient by 100 through reciprocal multiplication, exact below 32768
  function automatic logic [8:0] div100(input logic [14:0] x);
    logic [27:0] p;
    p = {13'd0, x} * 28'd5243;
    return p[27:19];
  endfunction

  function automatic logic [8:0] march_day(input logic [3:0] mi);
    unique case (mi)
      4'd0:  return 9'd0;
      4'd1:  return 9'd31;
      4'd2:  return 9'd61;
      4'd3:  return 9'd92;
      4'd4:  return 9'd122;
      4'd5:  return 9'd153;
      4'd6:  return 9'd184;
      4'd7:  return 9'd214;
      4'd8:  return 9'd245;
      4'd9:  return 9'd275;
      4'd10: return 9'd306;
      4'd11: return 9'd337;
      default: return 9'd0;
    endcase
  endfunction

  ev_state_t    state, state_next;
  date_fields_t f;
  logic [15:0]  y;
  logic         ok;
  logic [14:0]  ya;
  logic [8:0]   q100, q400;
  logic         lp;
  logic signed [24:0] days;
  logic signed [40:0] secs;
  logic [16:0]  tod;

  logic [16:0]  yfull;
  logic [14:0]  ya_c;
  logic [8:0]   yq;
  logic         z100;
  logic         lp_c;
  logic [3:0]   mi;
  logic [8:0]   doy;
  logic signed [24:0] dcalc;

  always_comb begin
    yfull = {2'd0, f.year};
    if (f.year >= 15'd70 && f.year <= 15'd99) yfull = yfull + 17'd1900;
    else if (f.year <= 15'd69) yfull = yfull + 17'd2000;
  end

  always_comb begin
    yq   = div100(y[14:0]);
    z100 = y[14:0] == {6'd0, yq} * 15'd100;
    lp_c = (y[1:0] == 2'd0 && !z100) || (z100 && yq[1:0] == 2'd0);
  end

  assign ya_c = (f.month <= 4'd2) ? y[14:0] - 15'd1 : y[14:0];

  // days from civil, using year shifted to start in March
  always_comb begin
    mi    = (f.month > 4'd2) ? f.month - 4'd3 : f.month + 4'd9;
    doy   = march_day(mi) + {4'd0, f.day} - 9'd1;
    dcalc = $signed({10'd0, ya} * 25'd365 + {12'd0, ya[14:2]} - {16'd0, q100} +
                    {16'd0, q400} + {16'd0, doy}) - 25'sd719468;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= EV_IDLE;
    end else begin
      state <= state_next;
      unique case (state)
        EV_IDLE: if (fields_valid) begin
          f <= fields;
        end
        EV_CHECK: begin
          y  <= yfull[15:0];
          ok <= f.hour_ok && f.day != 5'd0 && f.month != 4'd0 && f.month <= 4'd12 &&
                f.year_set && !f.year_big && yfull >= 17'(YEAR_MIN) &&
                yfull <= 17'(YEAR_MAX);
        end
        EV_DIV: begin
          ya   <= ya_c;
          q100 <= div100(ya_c);
          q400 <= div100({2'd0, ya_c[14:2]});
          lp   <= lp_c;
        end
        EV_DAYS: begin
          ok   <= ok && f.day <= month_len(f.month, lp);
          days <= dcalc;
          tod  <= 17'(f.hour) * 17'd3600 + 17'(f.minute) * 17'd60 + 17'(f.second);
        end
        EV_MUL: secs <= 41'(days) * 41'sd86400;
        EV_SUM: begin
          date_valid    <= ok;
          epoch_seconds <= ok ? secs + 41'(tod) : '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next   = state;
    fields_ready = 1'b0;
    valid        = 1'b0;
    unique case (state)
      EV_IDLE: begin
        fields_ready = 1'b1;
        if (fields_valid) state_next = EV_CHECK;
      end
      EV_CHECK: state_next = EV_DIV;
      EV_DIV:   state_next = EV_DAYS;
      EV_DAYS:  state_next = EV_MUL;
      EV_MUL:   state_next = EV_SUM;
      EV_SUM:   state_next = EV_OUT;
      EV_OUT: begin
        valid = 1'b1;
        if (ready) state_next = EV_IDLE;
      end
      default: state_next = EV_IDLE;
    endcase
  end

  a_zero: assert property (@(posedge clk) disable iff (rst)
    valid && !date_valid |-> epoch_seconds == '0) else $error("invalid date not zero");
  a_take: assert property (@(posedge clk) disable iff (rst)
    fields_ready |-> !valid) else $error("take while result pending");
  a_done: assert property (@(posedge clk) disable iff (rst)
    state == EV_SUM |=> valid) else $error("result not shown");

endmodule
`default_nettype wire

// ===== rtl/cookie_date_parser.sv =====
// Top level of the cookie date parser: tokenizer front, queue, converter back.
// Depends on cdp_pkg, cdp_front, cdp_queue and cdp_back.
// Bytes are taken one per cycle while ready is high; the request carrying the last
// byte passes through the front register and queue to the converter, which steps
// through check, divide, day count, multiply and sum before it shows the result.
// The converter takes no new date until its result is taken, so short strings fill
// the front register and the two-entry queue, and then hold the byte input.
`timescale 1ns / 1ps
`default_nettype none
module cookie_date_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         date_byte,
  input  wire logic               last_byte,
  input  wire logic               valid,
  output logic                    ready,
  output logic                    date_valid,
  output logic signed [40:0]      epoch_seconds,
  output logic                    out_valid,
  input  wire logic               out_ready
);
  import cdp_pkg::*;

  date_fields_t ff, qf;
  logic         ff_v, ff_r, qf_v, qf_r;

  cdp_front u_front (
    .clk, .rst, .date_byte, .last_byte, .valid, .ready,
    .fields(ff), .fields_valid(ff_v), .fields_ready(ff_r)
  );

  cdp_queue u_queue (
    .clk, .rst, .in_data(ff), .in_valid(ff_v), .in_ready(ff_r),
    .out_data(qf), .out_valid(qf_v), .out_ready(qf_r)
  );

  cdp_back u_back (
    .clk, .rst, .fields(qf), .fields_valid(qf_v), .fields_ready(qf_r),
    .date_valid, .epoch_seconds, .valid(out_valid), .ready(out_ready)
  );

endmodule
`default_nettype wire

// ===== sim/cdp_checker.sv =====
// Checker for the cookie date parser: watches both channels, predicts each date result.
// Depends on the ports of cookie_date_parser only.
`timescale 1ns / 1ps
module cdp_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         date_byte,
  input  wire logic               last_byte,
  input  wire logic               valid,
  input  wire logic               ready,
  input  wire logic               date_valid,
  input  wire logic signed [40:0] epoch_seconds,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  output int                      errors,
  output int                      pending,
  output int                      strings_seen,
  output int                      valid_dates
);

  typedef struct {
    logic        ok;
    logic [40:0] secs;
  } date_result_t;

  date_result_t expected_dates[$];

  int unsigned tok_len, tok_prefix, tok_flags, colons;
  int unsigned grp_val[3];
  bit          grp_seen[3];
  longint unsigned tok_num;
  bit          num_ovf;
  bit          have_time;
  int unsigned t_hour, t_min, t_sec;
  int unsigned day_f, month_f, year_f, yflags;

  function automatic bit delim(input int unsigned b);
    return b == 'h09 || (b >= 'h20 && b <= 'h2F) || (b >= 'h3B && b <= 'h40) ||
           (b >= 'h5B && b <= 'h60) || (b >= 'h7B && b <= 'h7E);
  endfunction

  function automatic int unsigned lc(input int unsigned b);
    return (b >= 'h41 && b <= 'h5A) ? (b | 'h20) : b;
  endfunction

  task automatic clear_token();
    tok_len = 0; tok_prefix = 0; tok_flags = 0; colons = 0;
    for (int i = 0; i < 3; i++) begin
      grp_val[i] = 0; grp_seen[i] = 0;
    end
    tok_num = 0; num_ovf = 0;
  endtask

  task automatic clear_all();
    clear_token();
    have_time = 0; t_hour = 0; t_min = 0; t_sec = 0;
    day_f = 0; month_f = 0; year_f = 0; yflags = 0;
  endtask

  task automatic add_byte(input int unsigned b);
    int unsigned d, v;
    if (tok_len < 3) tok_prefix |= b << (8 * tok_len);
    if (tok_len < 255) tok_len++;
    if (b >= 'h30 && b <= 'h39) begin
      d = b - 'h30;
      if (colons < 3) begin
        v = grp_val[colons] * 10 + d;
        grp_val[colons] = v > 100 ? 100 : v;
        grp_seen[colons] = 1;
      end
      if (!num_ovf) begin
        if (tok_num > (64'h7FFF_FFFF_FFFF_FFFF - d) / 10) num_ovf = 1;
        else tok_num = tok_num * 10 + d;
      end
    end else begin
      tok_flags |= 1;
      if (b == 'h3A) begin
        if (colons < 3) colons++;
      end else begin
        tok_flags |= 2;
      end
    end
  endtask

  function automatic int unsigned prefix_month();
    string names;
    int unsigned c0, c1, c2;
    names = "janfebmaraprmayjunjulaugsepoctnovdec";
    c0 = lc(tok_prefix & 'hFF);
    c1 = lc((tok_prefix >> 8) & 'hFF);
    c2 = lc((tok_prefix >> 16) & 'hFF);
    if (tok_len < 3) return 0;
    for (int i = 0; i < 12; i++)
      if (c0 == names[3*i] && c1 == names[3*i+1] && c2 == names[3*i+2]) return i + 1;
    return 0;
  endfunction

  task automatic close_token();
    int unsigned m;
    if (tok_len == 0) return;
    if (!have_time && colons == 2 && !tok_flags[1] && grp_seen[0] && grp_seen[1] &&
        grp_seen[2] && grp_val[0] <= 23 && grp_val[1] <= 59 && grp_val[2] <= 59) begin
      have_time = 1;
      t_hour = grp_val[0]; t_min = grp_val[1]; t_sec = grp_val[2];
      return;
    end
    if (day_f == 0 && !tok_flags[0] && tok_len <= 2 && tok_num >= 1 && tok_num <= 31) begin
      day_f = tok_num;
      return;
    end
    if (month_f == 0) begin
      m = prefix_month();
      if (m != 0) begin
        month_f = m;
        return;
      end
    end
    if (!yflags[0] && !tok_flags[0] && !num_ovf) begin
      if (tok_num > 32767) begin
        yflags = 3; year_f = 0;
      end else begin
        yflags = 1; year_f = tok_num;
      end
    end
  endtask

  function automatic date_result_t date_to_epoch();
    date_result_t r;
    longint y, m, d, era, yoe, doy, doe, days, lim;
    bit lp;
    r.ok = 0; r.secs = '0;
    if (day_f == 0 || month_f == 0 || !yflags[0] || !have_time || yflags[1]) return r;
    y = year_f;
    if (y >= 70 && y <= 99) y += 1900;
    else if (y <= 69) y += 2000;
    if (y < 1601 || y > 32767) return r;
    m = month_f; d = day_f;
    lp = (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    if (m == 2) lim = lp ? 29 : 28;
    else if (m == 4 || m == 6 || m == 9 || m == 11) lim = 30;
    else lim = 31;
    if (d > lim) return r;
    if (m <= 2) y -= 1;
    era = y / 400;
    yoe = y - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468;
    r.ok = 1;
    r.secs = days * 86400 + t_hour * 3600 + t_min * 60 + t_sec;
    return r;
  endfunction

  always @(posedge clk) begin
    date_result_t want;
    int bad;
    bad = 0;
    if (rst) begin
      clear_all();
      expected_dates.delete();
      errors <= 0; pending <= 0; strings_seen <= 0; valid_dates <= 0;
    end else begin
      if (valid && ready) begin
        if (delim(date_byte)) begin
          close_token();
          clear_token();
        end else begin
          add_byte(date_byte);
        end
        if (last_byte) begin
          close_token();
          want = date_to_epoch();
          expected_dates.push_back(want);
          strings_seen <= strings_seen + 1;
          if (want.ok) valid_dates <= valid_dates + 1;
          clear_all();
        end
      end
      if (out_valid && out_ready) begin
        if (expected_dates.size() == 0) begin
          $error("unexpected result: date_valid=%0d epoch_seconds=%0d",
                 date_valid, epoch_seconds);
          bad++;
        end else begin
          want = expected_dates.pop_front();
          if (date_valid !== want.ok) begin
            $error("date_valid: expected %0d, got %0d", want.ok, date_valid);
            bad++;
          end
          if (epoch_seconds !== want.secs) begin
            $error("epoch_seconds: expected %0d, got %0d",
                   $signed(want.secs), epoch_seconds);
            bad++;
          end
        end
      end
      errors <= errors + bad;
      pending <= expected_dates.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the cookie date parser: clock, reset, request stimulus, verdict.
// Depends on cookie_date_parser and cdp_checker.
`timescale 1ns / 1ps
module tb;

  logic               clk;
  logic               rst;
  logic [7:0]         date_byte;
  logic               last_byte;
  logic               valid;
  logic               ready;
  logic               date_valid;
  logic signed [40:0] epoch_seconds;
  logic               out_valid;
  logic               out_ready;
  int                 errors, pending, strings_seen, valid_dates;
  int                 bytes_sent;
  int                 idle_cycles;
  bit                 hold_off;
  bit                 timed_out;

  localparam int WATCHDOG = 20000;

  cookie_date_parser u_top (
    .clk(clk), .rst(rst), .date_byte(date_byte), .last_byte(last_byte),
    .valid(valid), .ready(ready), .date_valid(date_valid),
    .epoch_seconds(epoch_seconds), .out_valid(out_valid), .out_ready(out_ready)
  );

  cdp_checker u_checker (
    .clk(clk), .rst(rst), .date_byte(date_byte), .last_byte(last_byte),
    .valid(valid), .ready(ready), .date_valid(date_valid),
    .epoch_seconds(epoch_seconds), .out_valid(out_valid), .out_ready(out_ready),
    .errors(errors), .pending(pending), .strings_seen(strings_seen),
    .valid_dates(valid_dates)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_ready = 0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      n = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
      if (n > 0) begin
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (valid && ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (!rst && idle_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lastb, input bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      valid <= 0;
      repeat (n) @(posedge clk);
    end
    date_byte <= b;
    last_byte <= lastb;
    valid <= 1;
    @(posedge clk);
    while (!ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit gaps);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1, gaps);
    valid <= 0;
  endtask

  function automatic string rand_delims();
    string d;
    string pool;
    pool = "\t ,;-/@[`{~";
    d = "";
    repeat ($urandom_range(1, 2)) d = {d, string'(pool[$urandom_range(0, pool.len() - 1)])};
    return d;
  endfunction

  function automatic string two_digits(input int v);
    return $sformatf("%02d", v);
  endfunction

  function automatic string rand_token();
    string names, s;
    int k;
    names = "janfebmaraprmayjunjulaugsepoctnovdec";
    k = $urandom_range(0, 5);
    case (k)
      0: s = $sformatf("%0d", $urandom_range(0, 40000));
      1: s = $sformatf("%0d:%0d:%0d", $urandom_range(0, 30), $urandom_range(0, 70),
                       $urandom_range(0, 70));
      2: begin
        s = names.substr(3 * $urandom_range(0, 11), 3 * $urandom_range(0, 11) + 2);
      end
      3: s = "x9";
      default: begin
        s = "";
        repeat ($urandom_range(1, 5)) s = {s, string'(byte'($urandom_range(0, 255)))};
      end
    endcase
    return s;
  endfunction

  function automatic string rand_date();
    string names, mon, y, t, parts[4], s;
    int m, idx, j;
    string tmp;
    names = "JanFebMarAprMayJunJulAugSepOctNovDec";
    m = $urandom_range(0, 11);
    mon = names.substr(3 * m, 3 * m + 2);
    if ($urandom_range(0, 1)) mon = mon.tolower();
    if ($urandom_range(0, 3) == 0) mon = {mon, "ember"};
    case ($urandom_range(0, 5))
      0: y = two_digits($urandom_range(0, 99));
      1: y = $sformatf("%0d", $urandom_range(1590, 1610));
      2: y = $sformatf("%0d", $urandom_range(32760, 32775));
      3: y = $sformatf("%0d", 4 * $urandom_range(400, 600));
      default: y = $sformatf("%0d", $urandom_range(1900, 2400));
    endcase
    t = $sformatf("%s:%s:%s", two_digits($urandom_range(0, 24)),
                  two_digits($urandom_range(0, 60)), two_digits($urandom_range(0, 60)));
    parts[0] = $sformatf("%0d", $urandom_range(1, 31));
    parts[1] = mon;
    parts[2] = y;
    parts[3] = t;
    for (int i = 3; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = parts[i]; parts[i] = parts[j]; parts[j] = tmp;
    end
    s = ($urandom_range(0, 2) == 0) ? {rand_delims(), "Wed"} : "";
    for (int i = 0; i < 4; i++) s = {s, (s.len() > 0 ? rand_delims() : ""), parts[i]};
    idx = $urandom_range(0, 9);
    if (idx == 0) s = {s, rand_delims()};
    else if (idx == 1) s = {s, " ", rand_token()};
    return s;
  endfunction

  initial begin
    string s;
    string directed[$];
    rst = 1; valid = 0; date_byte = 0; last_byte = 0; hold_off = 0; bytes_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    directed = '{
      "Thu, 01 Jan 1970 00:00:00 GMT",
      "Sun, 06 Nov 1994 08:49:37 GMT",
      "31 dec 32767 23:59:59",
      "1 JAN 1601 00:00:00",
      "1 jan 1600 00:00:00",
      "1 jan 32768 00:00:00",
      "29 Feb 2000 12:00:00",
      "29 Feb 1900 12:00:00",
      "31 Apr 2020 01:02:03",
      "10 mar 69 1:2:3",
      "10 mar 70 1:2:3",
      "10 mar 99999999999999999999 1:2:3",
      "24:00:00 1 jan 2000",
      "1:2 1 jan 2000",
      "1 jan 2000",
      " ",
      "\t;{~`@[",
      "12 decem 2024 ::1 10:11:12",
      "7 sep 2021 10:11:12:13 x",
      "Wed 03-Aug-2022 05:06:07"
    };
    foreach (directed[i]) send_text(directed[i], 0);
    // full byte range, one string of all values then two lone bytes
    s = "";
    for (int b = 255; b >= 0; b--) s = {s, string'(byte'(b))};
    send_text(s, 0);
    send_byte(8'h00, 1, 0);
    valid <= 0;
    send_byte(8'hFF, 1, 0);
    valid <= 0;

    // pause until all results are back
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    // long receiver hold-off while bytes keep coming
    hold_off = 1;
    for (int i = 0; i < 10; i++) send_text(rand_date(), 0);

    while (bytes_sent < 1800) begin
      if ($urandom_range(0, 4) == 0) begin
        s = "";
        repeat ($urandom_range(1, 8)) s = {s, rand_token(), rand_delims()};
        send_text(s, 1);
      end else begin
        send_text(rand_date(), $urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 30) == 0) begin
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    valid <= 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Run covered %0d date bytes in %0d strings, %0d of them valid dates.",
             bytes_sent, strings_seen, valid_dates);
    if (errors == 0 && pending == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cdp_pkg.sv
rtl/cdp_front.sv
rtl/cdp_final.sv
rtl/cdp_queue.sv
rtl/cdp_back.sv
rtl/cookie_date_parser.sv
sim/cdp_checker.sv
sim/tb.sv
